[sv/cfhc_pkg.sv]
package cfhc_pkg;

  // Payload limits
  localparam int MAX_BYTES       = 8;
  localparam int BYTES_PER_STAGE = 2;
  localparam int CRC_STAGES      = (MAX_BYTES + BYTES_PER_STAGE - 1) / BYTES_PER_STAGE;
  localparam int PAYLOAD_W       = 64;
  localparam int LEN_W           = 4;

  // CRC generator
  localparam logic [7:0] CRC_POLY = 8'hA8;

  // Identifier field limits
  localparam logic [7:0] TYPE_MAX   = 8'h1F;
  localparam logic [7:0] TAG_MAX    = 8'h07;
  localparam logic [7:0] SENDER_MAX = 8'h0F;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_CRC        = 3'd1,
    ERR_NODE_RANGE = 3'd2,
    ERR_BAD_TYPE   = 3'd3,
    ERR_BAD_TAG    = 3'd4,
    ERR_BAD_SENDER = 3'd5,
    ERR_TOO_LONG   = 3'd6
  } err_code_t;

  typedef enum logic [2:0] {
    REG_OWN_NODE      = 3'd0,
    REG_MIN_NODE      = 3'd1,
    REG_MAX_NODE      = 3'd2,
    REG_BOARD_HANDLER = 3'd3,
    REG_DEVICE_BASE   = 3'd4
  } reg_index_t;

  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  typedef struct packed {
    logic [3:0] own_node;
    logic [3:0] min_node;
    logic [3:0] max_node;
    logic [7:0] board_handler;
    logic [7:0] device_base;
  } cfg_t;

  // Request as it travels down the CRC stages
  typedef struct packed {
    logic                 func;
    logic [28:0]          frame_id;
    logic [7:0]           msg_type;
    logic [7:0]           tag;
    logic [7:0]           sender;
    logic [7:0]           stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     remaining;
    logic                 too_long;
    logic [7:0]           crc;
  } pipe_t;

  // One payload byte through the CRC register, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] r;
    r = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[sv/cfhc_if.sv]
interface cfhc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [28:0] frame_id;
  logic [7:0]  msg_type;
  logic [7:0]  tag_in;
  logic [7:0]  sender_in;
  logic [7:0]  stamp_in;
  logic [63:0] payload;
  logic [3:0]  length;

  modport source (output valid, func, frame_id, msg_type, tag_in, sender_in, stamp_in,
                  payload, length, input ready);
  modport sink (input valid, func, frame_id, msg_type, tag_in, sender_in, stamp_in,
                payload, length, output ready);
endinterface

interface cfhc_rsp_if;
  logic                  valid;
  logic                  ready;
  cfhc_pkg::err_code_t   error_code;
  logic [31:0]           frame_out;
  logic [4:0]            type_out;
  logic [3:0]            source_node;
  logic [7:0]            handler_out;
  logic [2:0]            tag_out;
  logic [7:0]            stamp_out;
  logic [4:0]            crc_out;

  modport source (output valid, error_code, frame_out, type_out, source_node, handler_out,
                  tag_out, stamp_out, crc_out, input ready);
  modport sink (input valid, error_code, frame_out, type_out, source_node, handler_out,
                tag_out, stamp_out, crc_out, output ready);
endinterface

[sv/can_frame_header_crc5_codec.sv]
// Packs and unpacks 29-bit extended CAN identifiers (type, source node, sender,
// tag, CRC-5 over the payload, timestamp). One request enters per clock while
// the response side does not stall; each request passes through registered stages:
// the CRC is folded two payload bytes per register stage, and a last stage runs
// the field checks and holds the response. Stalls on the response side back up
// through the stages without loss; empty stages still take new requests.
// Configuration writes take effect on the next clock and should be made while
// no request is in flight.
module can_frame_header_crc5_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  cfhc_req_if.sink   req,
  cfhc_rsp_if.source rsp
);
  import cfhc_pkg::*;

  cfg_t  cfg;
  logic  stage_valid [CRC_STAGES+1];
  logic  stage_ready [CRC_STAGES+1];
  pipe_t stage_item  [CRC_STAGES+1];
  logic  too_long;

  cfhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Form the request entering the CRC chain
  assign too_long = 32'(req.length) > MAX_BYTES;

  always_comb begin
    stage_item[0].func      = req.func;
    stage_item[0].frame_id  = req.frame_id;
    stage_item[0].msg_type  = req.msg_type;
    stage_item[0].tag       = req.tag_in;
    stage_item[0].sender    = req.sender_in;
    stage_item[0].stamp     = req.stamp_in;
    stage_item[0].payload   = req.payload;
    stage_item[0].remaining = too_long ? '0 : req.length;
    stage_item[0].too_long  = too_long;
    stage_item[0].crc       = '0;
  end

  assign stage_valid[0] = req.valid;
  assign req.ready      = stage_ready[0];

  for (genvar g = 0; g < CRC_STAGES; g++) begin : g_crc
    cfhc_crc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  cfhc_check u_check (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (stage_valid[CRC_STAGES]),
    .in_ready (stage_ready[CRC_STAGES]),
    .in_item  (stage_item[CRC_STAGES]),
    .rsp      (rsp)
  );

endmodule

[sv/cfhc_cfg.sv]
module cfhc_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output cfhc_pkg::cfg_t cfg
);
  import cfhc_pkg::*;

  cfg_t regs;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.own_node      <= 4'd1;
      regs.min_node      <= 4'd1;
      regs.max_node      <= 4'd15;
      regs.board_handler <= 8'd0;
      regs.device_base   <= 8'd1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_OWN_NODE:      regs.own_node      <= cfg_data[3:0];
        REG_MIN_NODE:      regs.min_node      <= cfg_data[3:0];
        REG_MAX_NODE:      regs.max_node      <= cfg_data[3:0];
        REG_BOARD_HANDLER: regs.board_handler <= cfg_data;
        REG_DEVICE_BASE:   regs.device_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[sv/cfhc_crc_stage.sv]
module cfhc_crc_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfhc_pkg::pipe_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output cfhc_pkg::pipe_t out_item
);
  import cfhc_pkg::*;

  logic  valid;
  pipe_t item;
  pipe_t item_next;

  // Fold the low bytes into the CRC, then shift the rest down
  always_comb begin
    item_next = in_item;
    for (int b = 0; b < BYTES_PER_STAGE; b++) begin
      if (32'(in_item.remaining) > b) begin
        item_next.crc = crc_byte(item_next.crc, in_item.payload[8*b +: 8]);
      end
    end
    item_next.payload = in_item.payload >> (8 * BYTES_PER_STAGE);
    if (in_item.remaining > LEN_W'(BYTES_PER_STAGE)) begin
      item_next.remaining = in_item.remaining - LEN_W'(BYTES_PER_STAGE);
    end else begin
      item_next.remaining = '0;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

  // Stalled stage holds its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(item))
    else $error("crc stage dropped or changed a stalled request");

  a_len: assert property (@(posedge clk) disable iff (rst)
    valid && item.too_long |-> item.remaining == '0 && item.crc == 8'd0)
    else $error("oversized request reached the crc");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready && in_valid && in_item.remaining == '0 |=> item.crc == $past(in_item.crc))
    else $error("crc changed with no bytes left");

endmodule

[sv/cfhc_check.sv]
module cfhc_check (
  input  logic            clk,
  input  logic            rst,
  input  cfhc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfhc_pkg::pipe_t in_item,
  cfhc_rsp_if.source      rsp
);
  import cfhc_pkg::*;

  logic       valid;
  err_code_t  error_code, error_code_next;
  logic [31:0] frame_out, frame_out_next;
  logic [4:0] type_out, type_out_next;
  logic [3:0] source_node, source_node_next;
  logic [7:0] handler_out, handler_out_next;
  logic [2:0] tag_out, tag_out_next;
  logic [7:0] stamp_out, stamp_out_next;
  logic [4:0] crc_out, crc_out_next;

  logic [4:0] crc5;
  logic [4:0] rx_type;
  logic [3:0] rx_node;
  logic [3:0] rx_sender;
  logic [4:0] rx_crc;

  assign crc5      = in_item.crc[7:3];
  assign rx_type   = in_item.frame_id[28:24];
  assign rx_node   = in_item.frame_id[23:20];
  assign rx_sender = in_item.frame_id[19:16];
  assign rx_crc    = in_item.frame_id[12:8];

  // Check fields and build the response
  always_comb begin
    error_code_next  = ERR_NONE;
    frame_out_next   = '0;
    type_out_next    = '0;
    source_node_next = '0;
    handler_out_next = '0;
    tag_out_next     = '0;
    stamp_out_next   = '0;
    crc_out_next     = crc5;
    if (in_item.func == FUNC_DECODE) begin
      if (in_item.too_long) begin
        error_code_next = ERR_TOO_LONG;
      end else if (rx_crc != crc5) begin
        error_code_next = ERR_CRC;
      end else if (rx_node < cfg.min_node || rx_node > cfg.max_node) begin
        error_code_next = ERR_NODE_RANGE;
      end else if (rx_type == 5'd0) begin
        error_code_next = ERR_BAD_TYPE;
      end
      type_out_next    = rx_type;
      source_node_next = rx_node;
      if (rx_sender == 4'd0) begin
        handler_out_next = cfg.board_handler;
      end else begin
        handler_out_next = cfg.device_base + {4'd0, rx_sender} - 8'd1;
      end
      tag_out_next   = in_item.frame_id[15:13];
      stamp_out_next = in_item.frame_id[7:0];
    end else begin
      if (in_item.msg_type == 8'd0 || in_item.msg_type > TYPE_MAX) begin
        error_code_next = ERR_BAD_TYPE;
      end else if (in_item.tag > TAG_MAX) begin
        error_code_next = ERR_BAD_TAG;
      end else if (in_item.sender > SENDER_MAX) begin
        error_code_next = ERR_BAD_SENDER;
      end else if (in_item.too_long) begin
        error_code_next = ERR_TOO_LONG;
      end
      if (error_code_next == ERR_NONE) begin
        frame_out_next = {1'b1, 2'b00, in_item.msg_type[4:0], cfg.own_node,
                          in_item.sender[3:0], in_item.tag[2:0], crc5, in_item.stamp};
      end
    end
  end

  assign in_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      error_code  <= error_code_next;
      frame_out   <= frame_out_next;
      type_out    <= type_out_next;
      source_node <= source_node_next;
      handler_out <= handler_out_next;
      tag_out     <= tag_out_next;
      stamp_out   <= stamp_out_next;
      crc_out     <= crc_out_next;
    end
  end

  assign rsp.valid       = valid;
  assign rsp.error_code  = error_code;
  assign rsp.frame_out   = frame_out;
  assign rsp.type_out    = type_out;
  assign rsp.source_node = source_node;
  assign rsp.handler_out = handler_out;
  assign rsp.tag_out     = tag_out;
  assign rsp.stamp_out   = stamp_out;
  assign rsp.crc_out     = crc_out;

  // A built identifier only comes with a clean encode
  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    valid && frame_out != '0 |-> frame_out[31] && error_code == ERR_NONE)
    else $error("identifier built for a failed request");

  a_long_crc: assert property (@(posedge clk) disable iff (rst)
    valid && error_code == ERR_TOO_LONG |-> crc_out == 5'd0)
    else $error("crc reported for an oversized payload");

  a_enc_zero: assert property (@(posedge clk) disable iff (rst)
    valid && frame_out[31] |-> type_out == 5'd0 && source_node == 4'd0 &&
                               handler_out == 8'd0 && stamp_out == 8'd0)
    else $error("decode fields set in an encode response");

endmodule
